### rtl/kie_pkg.sv
// ----------------------------------------------------------------------------
// kie_pkg
// Shared types and constants of the Kepler invariant error pipeline.
// ----------------------------------------------------------------------------
package kie_pkg;

	// gravitational parameter, unsigned Q8.24
	localparam int unsigned MU_Q24 = 32'd16777216;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 40;
	localparam int HEAD_STAGES = 6;
	localparam int TAIL_STAGES = 6;
	localparam int LATENCY = HEAD_STAGES + SQRT_STEPS + DIV_STEPS + TAIL_STAGES;

	typedef enum logic [2:0] {
		REG_REF_L_X,
		REG_REF_L_Y,
		REG_REF_L_Z,
		REG_REF_A_X,
		REG_REF_A_Y,
		REG_REF_A_Z,
		REG_WEIGHT_L,
		REG_WEIGHT_A
	} reg_idx_t;

	typedef logic [47:0] cfg_data_t;
	typedef logic [63:0] q3232_t;

endpackage

### rtl/kepler_invariant_error_top.sv
// ----------------------------------------------------------------------------
// kepler_invariant_error_top
// Angular momentum and Runge-Lenz vector error of one orbital state.
// ----------------------------------------------------------------------------
// Fully pipelined: one word enters per cycle while in_stall is low; it passes
// through 6 head stages with the cross products, 32 square root stages of one
// root bit each, 40 divider stages of one quotient bit each and 6 tail stages
// with the distance squares and the weighting. The whole pipeline advances as
// one; in_stall is high exactly while a finished word waits at the output under
// out_stall. The user writes configuration through wr_en/wr_index/wr_data only
// while the pipeline is empty; the block itself does not enforce this.
module kepler_invariant_error_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  kie_pkg::reg_idx_t   wr_index,
	input  kie_pkg::cfg_data_t  wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  vel_z,
	output logic                out_valid,
	input  logic                out_stall,
	output kie_pkg::q3232_t     dist_l_sq,
	output kie_pkg::q3232_t     dist_a_sq,
	output kie_pkg::q3232_t     total_error,
	output logic                zero_radius
);
	import kie_pkg::*;

	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p11;
	} sqp_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
	} sq_st_t;

	typedef struct packed {
		logic [2:0][57:0] vls;
		logic [63:0]      dl;
		logic [2:0][62:0] pmu;
		logic [2:0]       neg;
		logic             zero;
	} side_t;

	typedef struct packed {
		logic [32:0] rem;
		logic        qb;
	} dvr_t;

	function automatic logic [63:0] abs64(logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic sqp_t sq_split(logic [63:0] x);
		sqp_t r;
		r.p00 = 64'(x[31:0]) * 64'(x[31:0]);
		r.p01 = 64'(x[31:0]) * 64'(x[63:32]);
		r.p11 = 64'(x[63:32]) * 64'(x[63:32]);
		return r;
	endfunction

	function automatic logic [127:0] sq_join(sqp_t p);
		return {p.p11, 64'b0} + {31'b0, p.p01, 33'b0} + {64'b0, p.p00};
	endfunction

	// sum of three squares, Q.64 -> Q32.32 with saturation
	function automatic logic [63:0] dist_sat(logic [127:0] a, logic [127:0] b,
			logic [127:0] c);
		logic [129:0] s;
		s = 130'(a) + 130'(b) + 130'(c);
		return (|s[129:96]) ? '1 : s[95:32];
	endfunction

	function automatic sq_st_t sqrt_step(sq_st_t s, logic [63:0] bitv);
		sq_st_t     r;
		logic [64:0] t;
		t = {1'b0, s.res} + {1'b0, bitv};
		r = s;
		if ({1'b0, s.n} >= t) begin
			r.n   = s.n - t[63:0];
			r.res = (s.res >> 1) + bitv;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	function automatic dvr_t div_step(logic [32:0] rem, logic bin, logic [32:0] norm);
		dvr_t        r;
		logic [33:0] cur;
		cur = {rem, bin};
		if (cur >= {1'b0, norm}) begin
			r.rem = 33'(cur - {1'b0, norm});
			r.qb  = 1'b1;
		end else begin
			r.rem = cur[32:0];
			r.qb  = 1'b0;
		end
		return r;
	endfunction

	// ---------------- configuration ----------------
	logic signed [47:0] ref_l_q [3];
	logic signed [47:0] ref_a_q [3];
	logic [31:0]        weight_l_q;
	logic [31:0]        weight_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ref_l_q[i] <= '0;
				ref_a_q[i] <= '0;
			end
			weight_l_q <= 32'd65536;
			weight_a_q <= 32'd65536;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REF_L_X:  ref_l_q[0] <= wr_data;
				REG_REF_L_Y:  ref_l_q[1] <= wr_data;
				REG_REF_L_Z:  ref_l_q[2] <= wr_data;
				REG_REF_A_X:  ref_a_q[0] <= wr_data;
				REG_REF_A_Y:  ref_a_q[1] <= wr_data;
				REG_REF_A_Z:  ref_a_q[2] <= wr_data;
				REG_WEIGHT_L: weight_l_q <= wr_data[31:0];
				REG_WEIGHT_A: weight_a_q <= wr_data[31:0];
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- head stages ----------------
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [31:0] pos [3];
	logic signed [31:0] vel [3];

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;
	assign vel[0] = vel_x;
	assign vel[1] = vel_y;
	assign vel[2] = vel_z;

	// s1: products of the inputs
	logic signed [63:0] rr_s1 [3];
	logic signed [63:0] pa_s1 [3];
	logic signed [63:0] pb_s1 [3];
	logic [31:0]        mag_s1 [3];
	logic [2:0]         neg_s1;
	logic signed [31:0] vel_s1 [3];

	// s2: sum of squares, L in Q16.48, MU scaled magnitudes
	logic [63:0]        sumsq_s2;
	logic signed [64:0] l_s2 [3];
	logic [62:0]        pmu_s2 [3];
	logic [2:0]         neg_s2;
	logic signed [31:0] vel_s2 [3];

	// s3: split products of v x L, L distance terms
	logic signed [64:0] ca_lo_s3 [3];
	logic signed [64:0] ca_hi_s3 [3];
	logic signed [64:0] cb_lo_s3 [3];
	logic signed [64:0] cb_hi_s3 [3];
	logic [63:0]        dl_abs_s3 [3];
	logic [63:0]        sumsq_s3;
	logic               zero_s3;
	logic [62:0]        pmu_s3 [3];
	logic [2:0]         neg_s3;

	// s4
	logic signed [97:0] ca_s4 [3];
	logic signed [97:0] cb_s4 [3];
	sqp_t               sql_s4 [3];
	logic [63:0]        sumsq_s4;
	logic               zero_s4;
	logic [62:0]        pmu_s4 [3];
	logic [2:0]         neg_s4;

	// s5
	logic signed [57:0] vls_s5 [3];
	logic [127:0]       sql_s5 [3];
	logic [63:0]        sumsq_s5;
	logic               zero_s5;
	logic [62:0]        pmu_s5 [3];
	logic [2:0]         neg_s5;

	// s6
	side_t              side_s6;
	logic [63:0]        sumsq_s6;

	logic signed [49:0] dl_d [3];
	logic signed [97:0] vl_d [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dl_d[i] = 50'($signed(l_s2[i][64:16])) - 50'(ref_l_q[i]);
			vl_d[i] = ca_s4[i] - cb_s4[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				// s1
				rr_s1[i]  <= pos[i] * pos[i];
				pa_s1[i]  <= pos[(i + 1) % 3] * vel[(i + 2) % 3];
				pb_s1[i]  <= pos[(i + 2) % 3] * vel[(i + 1) % 3];
				mag_s1[i] <= pos[i][31] ? 32'(-pos[i]) : 32'(pos[i]);
				neg_s1[i] <= pos[i][31];
				vel_s1[i] <= vel[i];
				// s2
				l_s2[i]   <= 65'(pa_s1[i]) - 65'(pb_s1[i]);
				pmu_s2[i] <= 63'(mag_s1[i]) * 63'(MU_Q24);
				neg_s2[i] <= neg_s1[i];
				vel_s2[i] <= vel_s1[i];
				// s3: v x L with L cut into a signed high and unsigned low half
				ca_lo_s3[i] <= vel_s2[(i + 1) % 3] * $signed({1'b0, l_s2[(i + 2) % 3][31:0]});
				ca_hi_s3[i] <= vel_s2[(i + 1) % 3] * $signed(l_s2[(i + 2) % 3][64:32]);
				cb_lo_s3[i] <= vel_s2[(i + 2) % 3] * $signed({1'b0, l_s2[(i + 1) % 3][31:0]});
				cb_hi_s3[i] <= vel_s2[(i + 2) % 3] * $signed(l_s2[(i + 1) % 3][64:32]);
				dl_abs_s3[i] <= abs64(64'(dl_d[i]));
				pmu_s3[i]    <= pmu_s2[i];
				neg_s3[i]    <= neg_s2[i];
				// s4
				ca_s4[i]  <= (98'(ca_hi_s3[i]) <<< 32) + 98'(ca_lo_s3[i]);
				cb_s4[i]  <= (98'(cb_hi_s3[i]) <<< 32) + 98'(cb_lo_s3[i]);
				sql_s4[i] <= sq_split(dl_abs_s3[i]);
				pmu_s4[i] <= pmu_s3[i];
				neg_s4[i] <= neg_s3[i];
				// s5: (v x L) in Q.32, floor
				vls_s5[i] <= vl_d[i][97:40];
				sql_s5[i] <= sq_join(sql_s4[i]);
				pmu_s5[i] <= pmu_s4[i];
				neg_s5[i] <= neg_s4[i];
				// s6
				side_s6.vls[i] <= vls_s5[i];
				side_s6.pmu[i] <= pmu_s5[i];
				side_s6.neg[i] <= neg_s5[i];
			end
			sumsq_s2     <= 64'(rr_s1[0]) + 64'(rr_s1[1]) + 64'(rr_s1[2]);
			sumsq_s3     <= sumsq_s2;
			zero_s3      <= (sumsq_s2 == '0);
			sumsq_s4     <= sumsq_s3;
			zero_s4      <= zero_s3;
			sumsq_s5     <= sumsq_s4;
			zero_s5      <= zero_s4;
			sumsq_s6     <= sumsq_s5;
			side_s6.zero <= zero_s5;
			side_s6.dl   <= dist_sat(sql_s5[0], sql_s5[1], sql_s5[2]);
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	side_t  sq_side_s [SQRT_STEPS];
	sq_st_t sq_st_s   [SQRT_STEPS];
	logic   sq_v_s    [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int SH = 62 - 2 * k;
		side_t  side_in;
		sq_st_t st_in;
		logic   v_in;

		if (k == 0) begin : g_first
			assign side_in = side_s6;
			assign st_in   = '{n: sumsq_s6, res: 64'd0};
			assign v_in    = v_s6;
		end else begin : g_next
			assign side_in = sq_side_s[k - 1];
			assign st_in   = sq_st_s[k - 1];
			assign v_in    = sq_v_s[k - 1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (en) begin
				sq_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[k] <= side_in;
				sq_st_s[k]   <= sqrt_step(st_in, 64'd1 << SH);
			end
		end
	end

	// ---------------- divider, one quotient bit per stage ----------------
	// dividend is pmu << 8; its top 31 bits seed the remainder, which stays
	// below the norm because |r_i| <= |r|
	side_t            dv_side_s [DIV_STEPS];
	logic [2:0][32:0] dv_rem_s  [DIV_STEPS];
	logic [2:0][39:0] dv_q_s    [DIV_STEPS];
	logic [32:0]      dv_norm_s [DIV_STEPS];
	logic             dv_v_s    [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		side_t            side_in;
		logic [2:0][32:0] rem_in;
		logic [2:0][39:0] q_in;
		logic [32:0]      norm_in;
		logic             v_in;
		dvr_t             step [3];
		logic [39:0]      dlo  [3];

		if (k == 0) begin : g_first
			assign side_in = sq_side_s[SQRT_STEPS - 1];
			assign norm_in = sq_st_s[SQRT_STEPS - 1].res[32:0];
			assign v_in    = sq_v_s[SQRT_STEPS - 1];
			for (genvar a = 0; a < 3; a++) begin : g_seed
				assign rem_in[a] = 33'(sq_side_s[SQRT_STEPS - 1].pmu[a][62:32]);
				assign q_in[a]   = '0;
			end
		end else begin : g_next
			assign side_in = dv_side_s[k - 1];
			assign norm_in = dv_norm_s[k - 1];
			assign v_in    = dv_v_s[k - 1];
			assign rem_in  = dv_rem_s[k - 1];
			assign q_in    = dv_q_s[k - 1];
		end

		always_comb begin
			for (int a = 0; a < 3; a++) begin
				dlo[a]  = {side_in.pmu[a][31:0], 8'b0};
				step[a] = div_step(rem_in[a], dlo[a][DIV_STEPS - 1 - k], norm_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (en) begin
				dv_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[k] <= side_in;
				dv_norm_s[k] <= norm_in;
				for (int a = 0; a < 3; a++) begin
					dv_rem_s[k][a] <= step[a].rem;
					dv_q_s[k][a]   <= {q_in[a][38:0], step[a].qb};
				end
			end
		end
	end

	// ---------------- tail stages ----------------
	side_t            dv_out;
	logic [2:0][39:0] q_out;
	logic signed [59:0] a_val [3];
	logic signed [60:0] da_d  [3];

	assign dv_out = dv_side_s[DIV_STEPS - 1];
	assign q_out  = dv_q_s[DIV_STEPS - 1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// A = (v x L) - sign(r_i) * MU * |r_i| / |r|
			if (dv_out.neg[i]) begin
				a_val[i] = 60'($signed(dv_out.vls[i])) + $signed({20'b0, q_out[i]});
			end else begin
				a_val[i] = 60'($signed(dv_out.vls[i])) - $signed({20'b0, q_out[i]});
			end
			da_d[i] = 61'(a_val[i]) - 61'(ref_a_q[i]);
		end
	end

	logic         v_t1, v_t2, v_t3, v_t4, v_t5;
	logic [63:0]  da_abs_t1 [3];
	sqp_t         sqa_t2    [3];
	logic [127:0] sqa_t3    [3];
	logic [63:0]  dl_t1, dl_t2, dl_t3, dl_t4, dl_t5;
	logic         zero_t1, zero_t2, zero_t3, zero_t4, zero_t5;
	logic [63:0]  da_t4, da_t5;
	logic [63:0]  pwl_lo_t5, pwl_hi_t5, pwa_lo_t5, pwa_hi_t5;
	logic [97:0]  tot_sum;

	assign tot_sum = (98'(pwl_hi_t5) << 32) + 98'(pwl_lo_t5)
		+ (98'(pwa_hi_t5) << 32) + 98'(pwa_lo_t5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1      <= 1'b0;
			v_t2      <= 1'b0;
			v_t3      <= 1'b0;
			v_t4      <= 1'b0;
			v_t5      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_t1      <= dv_v_s[DIV_STEPS - 1];
			v_t2      <= v_t1;
			v_t3      <= v_t2;
			v_t4      <= v_t3;
			v_t5      <= v_t4;
			out_valid <= v_t5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				da_abs_t1[i] <= abs64(64'(da_d[i]));
				sqa_t2[i]    <= sq_split(da_abs_t1[i]);
				sqa_t3[i]    <= sq_join(sqa_t2[i]);
			end
			dl_t1   <= dv_out.dl;
			zero_t1 <= dv_out.zero;
			dl_t2   <= dl_t1;
			zero_t2 <= zero_t1;
			dl_t3   <= dl_t2;
			zero_t3 <= zero_t2;
			dl_t4   <= dl_t3;
			zero_t4 <= zero_t3;
			da_t4   <= zero_t3 ? '1 : dist_sat(sqa_t3[0], sqa_t3[1], sqa_t3[2]);
			// weighting, distances cut into 32-bit halves
			pwl_lo_t5 <= 64'(weight_l_q) * 64'(dl_t4[31:0]);
			pwl_hi_t5 <= 64'(weight_l_q) * 64'(dl_t4[63:32]);
			pwa_lo_t5 <= 64'(weight_a_q) * 64'(da_t4[31:0]);
			pwa_hi_t5 <= 64'(weight_a_q) * 64'(da_t4[63:32]);
			dl_t5     <= dl_t4;
			da_t5     <= da_t4;
			zero_t5   <= zero_t4;
			// output word
			dist_l_sq   <= dl_t5;
			dist_a_sq   <= da_t5;
			zero_radius <= zero_t5;
			total_error <= (zero_t5 || (|tot_sum[97:80])) ? '1 : tot_sum[79:16];
		end
	end

endmodule

### rtl/kie_checker.sv
// ----------------------------------------------------------------------------
// kie_props
// Port-level checks of the Kepler invariant error pipeline.
// ----------------------------------------------------------------------------
module kie_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input kie_pkg::q3232_t     dist_l_sq,
	input kie_pkg::q3232_t     dist_a_sq,
	input kie_pkg::q3232_t     total_error,
	input logic                zero_radius
);
	import kie_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dist_l_sq)
			&& $stable(dist_a_sq) && $stable(total_error) && $stable(zero_radius))
		else $error("output word changed under stall");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow a blocked output word");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_radius |-> dist_a_sq == '1 && total_error == '1)
		else $error("zero radius word not saturated");

	a_idle_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("pipeline held without output stall");

endmodule

bind kepler_invariant_error_top kie_props u_kie_props (.*);
